// ===== rtl/rpa_pkg.sv =====
// rpa_pkg: shared types and constants for the range progression add block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rpa_pkg;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam int IDX_W   = 13;
  localparam int VAL_W   = 64;
  localparam int STEP_W  = 32;
  localparam int TAG_W   = VAL_W + STEP_W;

  localparam logic [IDX_W-1:0] COUNT_RESET = 13'd4096;

  // one lazy tag: constant part and per-position step count
  typedef struct packed {
    logic [VAL_W-1:0]  offset;
    logic [STEP_W-1:0] steps;
  } tag_t;

endpackage

`default_nettype wire

// ===== rtl/rpa_tag_ram.sv =====
// rpa_tag_ram: single write, single read tag memory with registered read data
// depends on rpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpa_tag_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire rpa_pkg::tag_t  wdata,
  input  wire logic           re,
  input  wire logic [AW-1:0]  raddr,
  output rpa_pkg::tag_t       rdata
);

  rpa_pkg::tag_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpa_cfg.sv =====
// rpa_cfg: apb register for element_count with clamped count output
// depends on rpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpa_cfg #(
  parameter int MAX_ELEMENTS = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [rpa_pkg::IDX_W-1:0]      used_count
);

  logic [rpa_pkg::IDX_W-1:0] element_count;

  assign pready = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= rpa_pkg::COUNT_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      element_count <= pwdata[rpa_pkg::IDX_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (!paddr[2]) begin
      prdata = 32'(element_count);
    end
  end

  // clamp to 1..MAX_ELEMENTS
  always_comb begin
    if (element_count == '0) begin
      used_count = rpa_pkg::IDX_W'(1);
    end else if (32'(element_count) > 32'(MAX_ELEMENTS)) begin
      used_count = rpa_pkg::IDX_W'(MAX_ELEMENTS);
    end else begin
      used_count = element_count;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/range_progression_add_point_query.sv =====
// range_progression_add_point_query: top level, sequencer over the tag memory
// depends on rpa_pkg, rpa_tag_ram, rpa_cfg
//
//   port group       dir  handshake           payload
//   input items      in   in_valid/in_stall   operation, index, right_index, load_value
//   result items     out  out_valid/out_stall query_value
//   configuration    in   apb                 element_count at address 0
//
// one item at a time; the tag memory read port sets the pace.
// add: per tree level, check and write the low bound, check and write the high bound, shift.
// query: walk leaf to root summing tags, then multiply and finish; load starts one level up.
// after reset a clearing pass writes 2*MAX_ELEMENTS entries, one per cycle,
// with in_stall high; a held result does not block the next item until it finishes.
`timescale 1ns / 1ps
`default_nettype none

module range_progression_add_point_query #(
  parameter int MAX_ELEMENTS = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 operation,
  input  wire logic [12:0]                index,
  input  wire logic [12:0]                right_index,
  input  wire logic signed [63:0]         load_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [63:0]              query_value,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int DEPTH = 2 * MAX_ELEMENTS;
  localparam int NW    = $clog2(DEPTH);
  localparam int HW    = NW + 1;
  localparam int VW    = rpa_pkg::VAL_W;
  localparam int IW    = rpa_pkg::IDX_W;
  // step total over one leaf-to-root path
  localparam int SW    = rpa_pkg::STEP_W + $clog2(HW + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_CHK, S_A_WLO, S_A_CHKHI, S_A_WHI, S_A_SHIFT,
    S_Q_ACC, S_MUL, S_FIN
  } state_t;

  state_t            state;
  logic [HW-1:0]     lo;
  logic [HW-1:0]     hi;
  logic [NW-1:0]     node;
  logic [NW-1:0]     leaf;
  logic [HW-1:0]     clr_cnt;
  logic [VW-1:0]     inc_offset;
  logic [VW-1:0]     sum_offset;
  logic [SW-1:0]     sum_steps;
  logic [VW-1:0]     prod;
  logic [IW-1:0]     pos;
  logic [VW-1:0]     value;
  logic              is_load;

  logic [IW-1:0]     used_count;
  logic [IW-1:0]     r_clamp;
  logic [HW-1:0]     leaf_in;
  logic [HW-1:0]     hi_in;
  logic              accept;
  logic              fin_send;

  logic              mem_we;
  logic [NW-1:0]     mem_waddr;
  rpa_pkg::tag_t     mem_wdata;
  logic              mem_re;
  logic [NW-1:0]     mem_raddr;
  rpa_pkg::tag_t     mem_rdata;

  rpa_cfg #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .used_count (used_count)
  );

  rpa_tag_ram #(.DEPTH(DEPTH), .AW(NW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // finished query can move into the result register
  assign fin_send = (state == S_FIN) && !is_load && (!out_valid || !out_stall);

  // leaf and half-open range bounds of the incoming transaction
  always_comb begin
    r_clamp = (right_index > used_count) ? used_count : right_index;
    leaf_in = HW'(MAX_ELEMENTS) + HW'(index) - HW'(1);
    hi_in   = HW'(MAX_ELEMENTS) + HW'(r_clamp);
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt[NW-1:0];
      end
      S_IDLE: begin
        mem_re    = 1'b1;
        mem_raddr = (operation == rpa_pkg::OP_LOAD) ? leaf_in[NW:1] : leaf_in[NW-1:0];
      end
      S_A_CHK: begin
        mem_re    = 1'b1;
        mem_raddr = lo[NW-1:0];
      end
      S_A_CHKHI: begin
        mem_re    = 1'b1;
        mem_raddr = hi[NW-1:0] - NW'(1);
      end
      S_A_WLO: begin
        mem_we           = 1'b1;
        mem_waddr        = lo[NW-1:0];
        mem_wdata.offset = mem_rdata.offset + inc_offset;
        mem_wdata.steps  = mem_rdata.steps + rpa_pkg::STEP_W'(1);
      end
      S_A_WHI: begin
        mem_we           = 1'b1;
        mem_waddr        = hi[NW-1:0] - NW'(1);
        mem_wdata.offset = mem_rdata.offset + inc_offset;
        mem_wdata.steps  = mem_rdata.steps + rpa_pkg::STEP_W'(1);
      end
      S_Q_ACC: begin
        mem_re    = (node != NW'(1));
        mem_raddr = node >> 1;
      end
      S_FIN: begin
        mem_we           = is_load;
        mem_waddr        = leaf;
        mem_wdata.offset = value - sum_offset - prod;
        mem_wdata.steps  = '0;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // result register: set by a finished query, cleared once taken
      if (fin_send) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + HW'(1);
          if (clr_cnt == HW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            pos        <= index;
            value      <= load_value;
            leaf       <= leaf_in[NW-1:0];
            node       <= (operation == rpa_pkg::OP_LOAD) ? leaf_in[NW:1] : leaf_in[NW-1:0];
            lo         <= leaf_in;
            hi         <= hi_in;
            inc_offset <= VW'(1) - VW'(index);
            sum_offset <= '0;
            sum_steps  <= '0;
            is_load    <= (operation == rpa_pkg::OP_LOAD);
            case (operation)
              rpa_pkg::OP_LOAD: begin
                if (index != '0 && index <= used_count) begin
                  state <= S_Q_ACC;
                end
              end
              rpa_pkg::OP_ADD: begin
                if (index != '0 && index <= used_count && index <= r_clamp) begin
                  state <= S_A_CHK;
                end
              end
              rpa_pkg::OP_QUERY: begin
                if (index != '0 && index <= used_count) begin
                  state <= S_Q_ACC;
                end else begin
                  state <= S_MUL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_A_CHK: begin
          if (lo >= hi) begin
            state <= S_IDLE;
          end else if (lo[0]) begin
            state <= S_A_WLO;
          end else begin
            state <= S_A_CHKHI;
          end
        end
        S_A_WLO: begin
          lo    <= lo + HW'(1);
          state <= S_A_CHKHI;
        end
        S_A_CHKHI: begin
          state <= hi[0] ? S_A_WHI : S_A_SHIFT;
        end
        S_A_WHI: begin
          hi    <= hi - HW'(1);
          state <= S_A_SHIFT;
        end
        S_A_SHIFT: begin
          lo    <= lo >> 1;
          hi    <= hi >> 1;
          state <= S_A_CHK;
        end
        S_Q_ACC: begin
          sum_offset <= sum_offset + mem_rdata.offset;
          sum_steps  <= sum_steps + SW'(mem_rdata.steps);
          node       <= node >> 1;
          if (node == NW'(1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= VW'(sum_steps * pos);
          state <= S_FIN;
        end
        S_FIN: begin
          if (is_load) begin
            state <= S_IDLE;
          end else if (fin_send) begin
            query_value <= sum_offset + prod;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== bench/range_progression_add_point_query_tb.sv =====
// range_progression_add_point_query_tb: self-checking bench for the point query block
// depends on rpa_pkg and range_progression_add_point_query; a flat element array predicts results
`timescale 1ns / 1ps
`default_nettype none

module range_progression_add_point_query_tb;

  localparam int NUM_ELEMS   = 4096;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 120;
  localparam int DIR_ROWS    = 25;
  localparam logic [2:0] ADDR_COUNT = 3'd0;
  localparam logic [1:0] OP_NONE    = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = '0;
  logic [12:0] index = '0;
  logic [12:0] right_index = '0;
  logic signed [63:0] load_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [63:0] query_value;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  range_progression_add_point_query DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .index(index), .right_index(right_index),
    .load_value(load_value), .out_valid(out_valid), .out_stall(out_stall),
    .query_value(query_value), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: element values and the element count register
  logic [63:0] elem_vals [1:NUM_ELEMS];
  logic [12:0] count_reg;
  logic [63:0] pending_values [$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_go = 0;
  bit hold_started = 0;
  int hold_cnt = 0;
  // typed expectation riding along with the current transaction
  logic row_typed = 1'b0;
  logic [63:0] row_value = '0;

  function automatic int active_count();
    int c;
    c = count_reg;
    if (c < 1) c = 1;
    if (c > NUM_ELEMS) c = NUM_ELEMS;
    return c;
  endfunction

  // apply one transaction to the element array, return query result if any
  task automatic apply_item(input logic [1:0] op, input logic [12:0] idx,
                            input logic [12:0] ridx, input logic [63:0] val,
                            output bit has_result, output logic [63:0] result);
    int n;
    int r;
    n = active_count();
    has_result = 0;
    result = '0;
    case (op)
      rpa_pkg::OP_LOAD: begin
        if (idx >= 1 && idx <= n) elem_vals[idx] = val;
      end
      rpa_pkg::OP_ADD: begin
        r = (ridx > n) ? n : ridx;
        if (idx >= 1 && idx <= n && idx <= r)
          for (int k = idx; k <= r; k++) elem_vals[k] += 64'(k - idx + 1);
      end
      rpa_pkg::OP_QUERY: begin
        has_result = 1;
        if (idx >= 1 && idx <= n) result = elem_vals[idx];
      end
      default: ;
    endcase
  endtask

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // input acceptance: predict and queue the expected value
  always @(posedge clk) begin
    bit has;
    logic [63:0] v;
    if (!rst && in_valid && !in_stall) begin
      apply_item(operation, index, right_index, load_value, has, v);
      if (has) pending_values.push_back(row_typed ? row_value : v);
    end
  end

  // result check
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_values.size() == 0) begin
        $error("query_value: expected nothing, actual %h", query_value);
        errors++;
      end else begin
        want = pending_values.pop_front();
        if (query_value !== want) begin
          $error("query_value: expected %h, actual %h", want, query_value);
          errors++;
        end
      end
    end
  end

  // receiver stall, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_go && !hold_started) begin
      hold_started <= 1;
      hold_cnt <= 3000;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // one transaction on the input channel
  task automatic send(input logic [1:0] op, input logic [12:0] idx, input logic [12:0] ridx,
                      input logic [63:0] val, input bit typed, input logic [63:0] tval);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    index <= idx;
    right_index <= ridx;
    load_value <= val;
    row_typed <= typed;
    row_value <= tval;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // register write through the apb port, block idle
  task automatic write_count(input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_COUNT;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    count_reg = data[12:0];
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // directed table
  typedef struct {
    logic [1:0]  op;
    logic [12:0] idx;
    logic [12:0] ridx;
    logic [63:0] val;
    bit          typed;
    logic [63:0] want;
  } row_t;

  localparam logic [63:0] VMAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] VMIN = 64'h8000_0000_0000_0000;

  row_t dir_rows [DIR_ROWS] = '{
    '{rpa_pkg::OP_QUERY, 13'd1,    13'd0,    64'd0, 1, 64'd0},
    '{rpa_pkg::OP_QUERY, 13'd4096, 13'd0,    64'd0, 1, 64'd0},
    '{rpa_pkg::OP_QUERY, 13'd0,    13'd0,    64'd0, 1, 64'd0},
    '{rpa_pkg::OP_QUERY, 13'd8191, 13'h1fff, 64'd0, 1, 64'd0},
    '{rpa_pkg::OP_LOAD,  13'd1,    13'd0,    VMAX,  0, 64'd0},
    '{rpa_pkg::OP_LOAD,  13'd4096, 13'h1fff, VMIN,  0, 64'd0},
    '{rpa_pkg::OP_LOAD,  13'd0,    13'd0,    64'hffff_ffff_ffff_ffff, 0, 64'd0},
    '{rpa_pkg::OP_LOAD,  13'd4097, 13'd0,    64'd5, 0, 64'd0},
    '{OP_NONE,           13'd2,    13'd9,    64'd7, 0, 64'd0},
    '{rpa_pkg::OP_QUERY, 13'd1,    13'd0,    64'd0, 1, VMAX},
    '{rpa_pkg::OP_QUERY, 13'd4096, 13'd0,    64'd0, 1, VMIN},
    '{rpa_pkg::OP_QUERY, 13'd4097, 13'd0,    64'd0, 1, 64'd0},
    '{rpa_pkg::OP_ADD,   13'd1,    13'd4096, 64'd0, 0, 64'd0},
    '{rpa_pkg::OP_QUERY, 13'd1,    13'd0,    64'd0, 1, VMIN},
    '{rpa_pkg::OP_QUERY, 13'd4096, 13'd0,    64'd0, 1, VMIN + 64'd4096},
    '{rpa_pkg::OP_ADD,   13'd5,    13'd3,    64'd0, 0, 64'd0},
    '{rpa_pkg::OP_ADD,   13'd0,    13'd10,   64'd0, 0, 64'd0},
    '{rpa_pkg::OP_ADD,   13'd4097, 13'h1fff, 64'd0, 0, 64'd0},
    '{rpa_pkg::OP_ADD,   13'd4000, 13'h1fff, 64'd0, 0, 64'd0},
    '{rpa_pkg::OP_ADD,   13'd7,    13'd7,    64'd0, 0, 64'd0},
    '{rpa_pkg::OP_LOAD,  13'd3,    13'd0,    64'd100, 0, 64'd0},
    '{rpa_pkg::OP_QUERY, 13'd3,    13'd0,    64'd0, 0, 64'd0},
    '{rpa_pkg::OP_QUERY, 13'd7,    13'd0,    64'd0, 0, 64'd0},
    '{rpa_pkg::OP_QUERY, 13'd4050, 13'd0,    64'd0, 0, 64'd0},
    '{rpa_pkg::OP_QUERY, 13'd2048, 13'd0,    64'd0, 0, 64'd0}
  };

  // random phase: loads first, then mostly in-range adds and queries, some noise
  task automatic run_phase(input int items);
    int n;
    int lo;
    int sel;
    logic [12:0] a;
    logic [12:0] b;
    n = active_count();
    for (int i = 0; i < items; i++) begin
      sel = $urandom_range(0, 99);
      a = 13'($urandom_range(1, n));
      b = 13'($urandom_range(a, n));
      if (i < 40) begin
        send(rpa_pkg::OP_LOAD, 13'($urandom_range(1, n)), 13'($urandom),
             {$urandom, $urandom}, 0, '0);
      end else if (sel < 8) begin
        send(2'($urandom), 13'($urandom), 13'($urandom), {$urandom, $urandom}, 0, '0);
      end else if (sel < 45) begin
        // short ranges anywhere in the array keep values small and traceable
        if ($urandom_range(0, 3) == 0) begin
          lo = $urandom_range(1, n);
          b = 13'($urandom_range(lo, (lo + 8 > n) ? n : lo + 8));
          a = 13'(lo);
        end
        send(rpa_pkg::OP_ADD, a, b, {$urandom, $urandom}, 0, '0);
      end else if (sel < 93) begin
        send(rpa_pkg::OP_QUERY, a, 13'($urandom), {$urandom, $urandom}, 0, '0);
      end else begin
        send(rpa_pkg::OP_LOAD, a, 13'($urandom), {$urandom, $urandom}, 0, '0);
      end
    end
  endtask

  initial begin
    for (int k = 1; k <= NUM_ELEMS; k++) elem_vals[k] = '0;
    count_reg = rpa_pkg::COUNT_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset count
    foreach (dir_rows[i])
      send(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].ridx, dir_rows[i].val,
           dir_rows[i].typed, dir_rows[i].want);
    drain();

    send_idle_pct = 31;
    recv_idle_pct = 52;
    write_count(32'd16);
    run_phase(500);
    drain();

    send_idle_pct = 52;
    recv_idle_pct = 31;
    write_count(32'h1fff);
    run_phase(450);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_count(32'd0);
    run_phase(300);
    drain();

    // long receiver hold while the sender keeps going
    write_count(32'd300);
    hold_go = 1;
    run_phase(500);
    drain();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
